/* design/mdw_pkg.sv */
// Shared types and constants of the multichannel I2C DAC writer.
package mdw_pkg;

	localparam int VALUE_BITS = 12;
	localparam int SDA_LINES = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

	localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_COMMAND = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRETCH_LIMIT = 8'd3;

	localparam logic [6:0] RST_DEVICE_ADDRESS = 7'd96;
	localparam logic [7:0] RST_WRITE_COMMAND = 8'd64;
	localparam logic [15:0] RST_HALF_PERIOD = 16'd48;
	localparam logic [15:0] RST_STRETCH_LIMIT = 16'd1000;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_ST_STRETCH,
		PH_ST_HOLD,
		PH_ST_LOW,
		PH_BIT_SETUP,
		PH_BIT_STRETCH,
		PH_BIT_HIGH,
		PH_ACK_SETUP,
		PH_ACK_STRETCH,
		PH_ACK_HIGH,
		PH_STOP_LOW,
		PH_STOP_STRETCH,
		PH_STOP_HIGH,
		PH_STOP_END
	} phase_t;

	typedef struct packed {
		logic op;
		logic [2:0] channel;
		logic [15:0] level;
		logic fast_mode;
		logic scl_sensed;
		logic [SDA_LINES-1:0] sda_sensed;
	} req_item_t;

	typedef struct packed {
		logic scl_level;
		logic [SDA_LINES-1:0] sda_levels;
		logic busy_res;
		logic done_res;
		logic ack_ok;
		logic rejected;
	} res_item_t;

	// Classified item as it waits in the queue.
	typedef struct packed {
		logic op;
		logic ch_ok;
		logic [2:0] channel;
		logic [VALUE_BITS-1:0] value;
		logic fast;
		logic scl;
		logic [SDA_LINES-1:0] sda;
	} q_item_t;

	typedef struct packed {
		logic en;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_ctl_t;

endpackage

/* design/mdw_front.sv */
// Front stage: takes items, saturates the level and checks the channel.
module mdw_front #(
	parameter int CHANNELS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  mdw_pkg::req_item_t  req_item,
	input  logic                q_full,
	output logic                q_push,
	output mdw_pkg::q_item_t    q_item
);
	import mdw_pkg::*;

	localparam logic [3:0] CH_LIMIT = 4'(CHANNELS);

	logic     valid_s1;
	q_item_t  item_s1;
	q_item_t  item_d;
	logic     accept;

	always_comb begin
		item_d.op = req_item.op;
		item_d.ch_ok = ({1'b0, req_item.channel} < CH_LIMIT);
		item_d.channel = req_item.channel;
		item_d.value = (req_item.level > 16'(VALUE_MAX)) ? VALUE_MAX
			: req_item.level[VALUE_BITS-1:0];
		item_d.fast = req_item.fast_mode;
		item_d.scl = req_item.scl_sensed;
		item_d.sda = req_item.sda_sensed;
	end

	assign req_stall = valid_s1 && q_full;
	assign accept = req_valid && !req_stall;
	assign q_push = valid_s1 && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* design/mdw_queue.sv */
// Short queue of classified items between the front stage and the bus engine.
module mdw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mdw_pkg::q_item_t  push_item,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output mdw_pkg::q_item_t  head_item
);
	import mdw_pkg::*;

	q_item_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	logic               do_pop;

	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item = mem_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* design/mdw_engine.sv */
// Bus engine: configuration registers, I2C phase machine and the result register.
module mdw_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  mdw_pkg::cfg_wr_t   cfg_wr,
	input  logic               head_valid,
	input  mdw_pkg::q_item_t   head_item,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output mdw_pkg::res_item_t res_item
);
	import mdw_pkg::*;

	logic [6:0]   dev_addr_q;
	logic [7:0]   cmd_q;
	logic [15:0]  half_q;
	logic [15:0]  limit_q;

	phase_t       phase_q, phase_d;
	logic [3:0]   bit_cnt_q, bit_cnt_d;
	logic [1:0]   byte_idx_q, byte_idx_d;
	logic [7:0]   shift_q, shift_d;
	logic [15:0]  wait_q, wait_d;
	logic [15:0]  stretch_q, stretch_d;
	logic         ack_q, ack_d;
	logic [2:0]   chan_q, chan_d;
	logic [VALUE_BITS-1:0] value_q, value_d;
	logic         fast_q, fast_d;
	logic         scl_q, scl_d;
	logic [SDA_LINES-1:0] sda_q, sda_d;

	logic         res_valid_q;
	res_item_t    res_q;

	logic         step;
	logic         is_req;
	logic         req_ok;
	logic         waited;
	logic         stretched;
	logic [SDA_LINES-1:0] line_mask;
	logic         nack;
	logic [3:0]   bit_cnt_inc;
	logic         last_byte;
	logic [1:0]   load_idx;
	logic [7:0]   load_byte;
	logic         done;
	logic         ok;
	logic         rej;

	function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic [6:0] dev,
			input logic [7:0] cmd, input logic [VALUE_BITS-1:0] val, input logic fast);
		logic [7:0] b;
		if (idx == 2'd0) begin
			b = {dev, 1'b0};
		end else if (fast) begin
			b = (idx == 2'd1) ? {4'h0, val[11:8]} : val[7:0];
		end else if (idx == 2'd1) begin
			b = cmd;
		end else if (idx == 2'd2) begin
			b = val[11:4];
		end else begin
			b = {val[3:0], 4'h0};
		end
		return b;
	endfunction

	function automatic logic [SDA_LINES-1:0] drive(input logic b,
			input logic [SDA_LINES-1:0] mask);
		return b ? '1 : ~mask;
	endfunction

	// One queue entry is consumed in every cycle that the result register can take it.
	assign step = head_valid && (!res_valid_q || !res_stall);
	assign pop = step;
	assign is_req = (head_item.op == OP_WRITE);
	assign req_ok = (phase_q == PH_IDLE) && head_item.ch_ok;

	assign waited = (wait_q >= half_q);
	assign stretched = head_item.scl || (stretch_q >= limit_q);
	// A channel beyond the four lines owns no SDA bit and sees every ACK as a NACK.
	assign line_mask = chan_q[2] ? '0 : (SDA_LINES'(1) << chan_q[1:0]);
	assign nack = (line_mask == '0) ? 1'b1 : |(head_item.sda & line_mask);
	assign bit_cnt_inc = bit_cnt_q + 4'd1;
	assign last_byte = byte_idx_q >= (fast_q ? 2'd2 : 2'd3);
	assign load_idx = (phase_q == PH_ACK_HIGH) ? byte_idx_q + 2'd1 : 2'd0;
	assign load_byte = byte_for(load_idx, dev_addr_q, cmd_q, value_q, fast_q);

	always_comb begin
		phase_d = phase_q;
		if (step) begin
			if (is_req) begin
				if (req_ok) begin
					phase_d = PH_ST_STRETCH;
				end
			end else begin
				case (phase_q)
					PH_IDLE: phase_d = PH_IDLE;
					PH_ST_STRETCH: if (stretched) phase_d = PH_ST_HOLD;
					PH_ST_HOLD: if (waited) phase_d = PH_ST_LOW;
					PH_ST_LOW: if (waited) phase_d = PH_BIT_SETUP;
					PH_BIT_SETUP: if (waited) phase_d = PH_BIT_STRETCH;
					PH_BIT_STRETCH: if (stretched) phase_d = PH_BIT_HIGH;
					PH_BIT_HIGH: begin
						if (waited) begin
							phase_d = (bit_cnt_inc >= 4'd8) ? PH_ACK_SETUP : PH_BIT_SETUP;
						end
					end
					PH_ACK_SETUP: if (waited) phase_d = PH_ACK_STRETCH;
					PH_ACK_STRETCH: if (stretched) phase_d = PH_ACK_HIGH;
					PH_ACK_HIGH: begin
						if (waited) begin
							phase_d = last_byte ? PH_STOP_LOW : PH_BIT_SETUP;
						end
					end
					PH_STOP_LOW: if (waited) phase_d = PH_STOP_STRETCH;
					PH_STOP_STRETCH: if (stretched) phase_d = PH_STOP_HIGH;
					PH_STOP_HIGH: if (waited) phase_d = PH_STOP_END;
					PH_STOP_END: if (waited) phase_d = PH_IDLE;
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	always_comb begin
		bit_cnt_d = bit_cnt_q;
		byte_idx_d = byte_idx_q;
		shift_d = shift_q;
		wait_d = wait_q;
		stretch_d = stretch_q;
		ack_d = ack_q;
		chan_d = chan_q;
		value_d = value_q;
		fast_d = fast_q;
		scl_d = scl_q;
		sda_d = sda_q;
		done = 1'b0;
		ok = 1'b0;
		rej = 1'b0;
		if (step) begin
			if (is_req) begin
				if (!req_ok) begin
					rej = 1'b1;
				end else begin
					chan_d = head_item.channel;
					value_d = head_item.value;
					fast_d = head_item.fast;
					ack_d = 1'b1;
					wait_d = '0;
					stretch_d = '0;
					bit_cnt_d = '0;
					byte_idx_d = '0;
					shift_d = '0;
					scl_d = 1'b1;
					sda_d = '1;
				end
			end else begin
				if (phase_q inside {PH_ST_STRETCH, PH_BIT_STRETCH, PH_ACK_STRETCH,
						PH_STOP_STRETCH}) begin
					stretch_d = stretched ? '0 : stretch_q + 16'd1;
				end
				if (phase_q inside {[PH_ST_HOLD:PH_ST_LOW], PH_BIT_SETUP, PH_BIT_HIGH,
						PH_ACK_SETUP, PH_ACK_HIGH, PH_STOP_LOW, [PH_STOP_HIGH:PH_STOP_END]})
						begin
					wait_d = waited ? '0 : wait_q + 16'd1;
				end
				if (waited) begin
					case (phase_q)
						PH_ST_HOLD: sda_d = drive(1'b0, line_mask);
						PH_ST_LOW: begin
							scl_d = 1'b0;
							byte_idx_d = load_idx;
							shift_d = load_byte;
							bit_cnt_d = '0;
							sda_d = drive(load_byte[7], line_mask);
						end
						PH_BIT_SETUP: scl_d = 1'b1;
						PH_BIT_HIGH: begin
							scl_d = 1'b0;
							shift_d = {shift_q[6:0], 1'b0};
							bit_cnt_d = bit_cnt_inc;
							sda_d = (bit_cnt_inc >= 4'd8) ? '1 : drive(shift_q[6], line_mask);
						end
						PH_ACK_SETUP: scl_d = 1'b1;
						PH_ACK_HIGH: begin
							ack_d = ack_q & ~nack;
							scl_d = 1'b0;
							if (last_byte) begin
								sda_d = drive(1'b0, line_mask);
							end else begin
								byte_idx_d = load_idx;
								shift_d = load_byte;
								bit_cnt_d = '0;
								sda_d = drive(load_byte[7], line_mask);
							end
						end
						PH_STOP_LOW: scl_d = 1'b1;
						PH_STOP_HIGH: sda_d = '1;
						PH_STOP_END: begin
							done = 1'b1;
							ok = ack_q;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= RST_DEVICE_ADDRESS;
			cmd_q <= RST_WRITE_COMMAND;
			half_q <= RST_HALF_PERIOD;
			limit_q <= RST_STRETCH_LIMIT;
		end else if (cfg_wr.en) begin
			case (cfg_wr.index)
				CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_wr.data[6:0];
				CFG_WRITE_COMMAND: cmd_q <= cfg_wr.data[7:0];
				CFG_HALF_PERIOD: half_q <= cfg_wr.data;
				CFG_STRETCH_LIMIT: limit_q <= cfg_wr.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_cnt_q <= '0;
			byte_idx_q <= '0;
			shift_q <= '0;
			wait_q <= '0;
			stretch_q <= '0;
			ack_q <= 1'b1;
			chan_q <= '0;
			value_q <= '0;
			fast_q <= 1'b0;
			scl_q <= 1'b1;
			sda_q <= '1;
			res_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			byte_idx_q <= byte_idx_d;
			shift_q <= shift_d;
			wait_q <= wait_d;
			stretch_q <= stretch_d;
			ack_q <= ack_d;
			chan_q <= chan_d;
			value_q <= value_d;
			fast_q <= fast_d;
			scl_q <= scl_d;
			sda_q <= sda_d;
			if (step) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q.scl_level <= scl_d;
			res_q.sda_levels <= sda_d;
			res_q.busy_res <= (phase_d != PH_IDLE);
			res_q.done_res <= done;
			res_q.ack_ok <= ok;
			res_q.rejected <= rej;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item = res_q;

endmodule

/* design/multichannel_i2c_dac_writer.sv */
// Top level of the multichannel I2C DAC writer: front stage, queue and bus engine.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  req     | req_valid/req_stall| req_item: op, channel, level, fast_mode, pins
//  res     | res_valid/res_stall| res_item: scl, sda lines, busy, done, ack, rejected
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (ready is always high)
//
// One item is taken and one result given per clock while neither side stalls; the bus engine
// handles one queued item per cycle while the result register can take it, which sets the figure.
// An item passes the front-stage register, a queue entry and the result register on its way out.
// Reset returns the bus to released lines, the phase machine to idle and the
// registers to their defaults. A stalled result holds in the output register
// while up to four further items gather in the queue and one in the front stage.
module multichannel_i2c_dac_writer #(
	parameter int CHANNELS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  mdw_pkg::req_item_t                  req_item,
	output logic                                res_valid,
	input  logic                                res_stall,
	output mdw_pkg::res_item_t                  res_item,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mdw_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mdw_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import mdw_pkg::*;

	q_ctl_t   qctl;
	q_item_t  push_item;
	q_item_t  head_item;
	logic     head_valid;
	logic     pop;
	cfg_wr_t  cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr.en = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data = cfg_data;

	mdw_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item (req_item),
		.q_full   (qctl.full),
		.q_push   (qctl.push),
		.q_item   (push_item)
	);

	mdw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (qctl.push),
		.push_item (push_item),
		.full      (qctl.full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	mdw_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.head_valid(head_valid),
		.head_item (head_item),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

/* design/mdw_checker.sv */
// Port-level checks of the writer's results, bound to the top level.
module mdw_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input mdw_pkg::res_item_t res_item
);
	import mdw_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result item changed");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.done_res |-> !res_item.busy_res)
		else $error("done reported while still busy");

	a_ack_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.ack_ok |-> res_item.done_res)
		else $error("ack_ok without done");

	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.rejected |-> !res_item.done_res)
		else $error("rejected item also reported done");

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.busy_res |->
			res_item.scl_level && (res_item.sda_levels == '1))
		else $error("bus lines not released while idle");

endmodule

bind multichannel_i2c_dac_writer mdw_checker u_mdw_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for the multichannel I2C DAC writer, with its own model of the bus engine.
module tb;
	import mdw_pkg::*;

	localparam int LINES = 4;

	typedef enum logic [1:0] {ROW_ITEM, ROW_REG, ROW_DRAIN} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		req_item_t item;
		logic typed;
		res_item_t want;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] val;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_item_t req_item;
	logic res_valid;
	logic res_stall;
	res_item_t res_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Register copies.
	logic [6:0] dev_addr;
	logic [7:0] cmd_byte;
	logic [15:0] half_ticks;
	logic [15:0] stretch_lim;

	// Bus engine copy.
	phase_t m_phase;
	logic [3:0] m_bits;
	logic [1:0] m_byte;
	logic [7:0] m_shift;
	logic [15:0] m_wait;
	logic [15:0] m_stretch;
	logic m_ack;
	logic [1:0] m_chan;
	logic [VALUE_BITS-1:0] m_value;
	logic m_fast;
	logic m_scl;
	logic [SDA_LINES-1:0] m_sda;

	res_item_t pin_results[$];
	int error_count;
	int items_sent;
	int requests_sent;
	int results_seen;
	int writes_done;
	int writes_acked;
	int refusals;
	bit steady_feed;

	multichannel_i2c_dac_writer #(.CHANNELS(LINES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic res_item_t bus_pins(logic scl, logic [SDA_LINES-1:0] sda, logic busy,
		logic done, logic ok, logic rej);
		return '{scl_level: scl, sda_levels: sda, busy_res: busy, done_res: done,
			ack_ok: ok, rejected: rej};
	endfunction

	task automatic clear_model();
		dev_addr = RST_DEVICE_ADDRESS;
		cmd_byte = RST_WRITE_COMMAND;
		half_ticks = RST_HALF_PERIOD;
		stretch_lim = RST_STRETCH_LIMIT;
		m_phase = PH_IDLE;
		m_bits = '0;
		m_byte = '0;
		m_shift = '0;
		m_wait = '0;
		m_stretch = '0;
		m_ack = 1'b1;
		m_chan = '0;
		m_value = '0;
		m_fast = 1'b0;
		m_scl = 1'b1;
		m_sda = '1;
	endtask

	function automatic logic half_elapsed();
		if (m_wait < half_ticks) begin
			m_wait++;
			return 1'b0;
		end
		m_wait = '0;
		return 1'b1;
	endfunction

	function automatic logic scl_seen(logic scl);
		if (scl || m_stretch >= stretch_lim) begin
			m_stretch = '0;
			return 1'b1;
		end
		m_stretch++;
		return 1'b0;
	endfunction

	function automatic void drive_lines(logic b);
		m_sda = '1;
		if (!b) m_sda[m_chan] = 1'b0;
	endfunction

	function automatic logic [7:0] byte_at(logic [1:0] idx);
		if (idx == 2'd0) return {dev_addr, 1'b0};
		if (m_fast) return (idx == 2'd1) ? {4'h0, m_value[11:8]} : m_value[7:0];
		if (idx == 2'd1) return cmd_byte;
		if (idx == 2'd2) return m_value[11:4];
		return {m_value[3:0], 4'h0};
	endfunction

	// The address and command are read here, when their byte is loaded.
	function automatic void next_byte(logic [1:0] idx);
		m_byte = idx;
		m_shift = byte_at(idx);
		m_bits = '0;
		drive_lines(m_shift[7]);
		m_phase = PH_BIT_SETUP;
	endfunction

	function automatic res_item_t bus_step(req_item_t it);
		logic done;
		logic ok;
		logic rej;
		done = 1'b0;
		ok = 1'b0;
		rej = 1'b0;
		if (it.op == OP_WRITE) begin
			if (m_phase != PH_IDLE || it.channel >= LINES) begin
				rej = 1'b1;
			end else begin
				m_chan = it.channel[1:0];
				m_value = (it.level > VALUE_MAX) ? VALUE_MAX : it.level[VALUE_BITS-1:0];
				m_fast = it.fast_mode;
				m_ack = 1'b1;
				m_wait = '0;
				m_stretch = '0;
				m_bits = '0;
				m_byte = '0;
				m_shift = '0;
				m_scl = 1'b1;
				m_sda = '1;
				m_phase = PH_ST_STRETCH;
			end
		end else begin
			case (m_phase)
				PH_ST_STRETCH: if (scl_seen(it.scl_sensed)) m_phase = PH_ST_HOLD;
				PH_ST_HOLD: if (half_elapsed()) begin
					drive_lines(1'b0);
					m_phase = PH_ST_LOW;
				end
				PH_ST_LOW: if (half_elapsed()) begin
					m_scl = 1'b0;
					next_byte(2'd0);
				end
				PH_BIT_SETUP: if (half_elapsed()) begin
					m_scl = 1'b1;
					m_phase = PH_BIT_STRETCH;
				end
				PH_BIT_STRETCH: if (scl_seen(it.scl_sensed)) m_phase = PH_BIT_HIGH;
				PH_BIT_HIGH: if (half_elapsed()) begin
					m_scl = 1'b0;
					m_shift = m_shift << 1;
					m_bits = m_bits + 4'd1;
					if (m_bits >= 4'd8) begin
						drive_lines(1'b1);
						m_phase = PH_ACK_SETUP;
					end else begin
						drive_lines(m_shift[7]);
						m_phase = PH_BIT_SETUP;
					end
				end
				PH_ACK_SETUP: if (half_elapsed()) begin
					m_scl = 1'b1;
					m_phase = PH_ACK_STRETCH;
				end
				PH_ACK_STRETCH: if (scl_seen(it.scl_sensed)) m_phase = PH_ACK_HIGH;
				PH_ACK_HIGH: if (half_elapsed()) begin
					// A high line on the selected channel is a NACK; the write goes on regardless.
					m_ack = m_ack & ~it.sda_sensed[m_chan];
					m_scl = 1'b0;
					if (m_byte >= (m_fast ? 2'd2 : 2'd3)) begin
						drive_lines(1'b0);
						m_phase = PH_STOP_LOW;
					end else begin
						next_byte(m_byte + 2'd1);
					end
				end
				PH_STOP_LOW: if (half_elapsed()) begin
					m_scl = 1'b1;
					m_phase = PH_STOP_STRETCH;
				end
				PH_STOP_STRETCH: if (scl_seen(it.scl_sensed)) m_phase = PH_STOP_HIGH;
				PH_STOP_HIGH: if (half_elapsed()) begin
					drive_lines(1'b1);
					m_phase = PH_STOP_END;
				end
				PH_STOP_END: if (half_elapsed()) begin
					done = 1'b1;
					ok = m_ack;
					m_phase = PH_IDLE;
				end
				default: m_phase = PH_IDLE;
			endcase
		end
		return bus_pins(m_scl, m_sda, m_phase != PH_IDLE, done, ok, rej);
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_item_t pin_tick(int scl_pct);
		req_item_t it;
		it = '0;
		it.op = OP_TICK;
		it.channel = 3'($urandom);
		it.level = 16'($urandom);
		it.fast_mode = 1'($urandom);
		it.scl_sensed = ($urandom_range(0, 99) < scl_pct);
		// Lines are mostly pulled low, so that whole writes are often acknowledged.
		it.sda_sensed = ($urandom_range(0, 3) == 0) ? 4'($urandom)
			: 4'($urandom & $urandom & $urandom);
		return it;
	endfunction

	function automatic req_item_t dac_request();
		req_item_t it;
		it = pin_tick(50);
		it.op = OP_WRITE;
		it.channel = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(4, 7))
			: 3'($urandom_range(0, 3));
		case ($urandom_range(0, 5))
			0: it.level = 16'd0;
			1: it.level = 16'd4095;
			2: it.level = 16'd4096;
			3: it.level = 16'hFFFF;
			4: it.level = 16'($urandom_range(0, 4095));
			default: it.level = 16'($urandom);
		endcase
		return it;
	endfunction

	function automatic plan_row_t row_item(logic op, logic [2:0] ch, logic [15:0] lvl,
		logic fast, logic scl, logic [3:0] sda, logic typed, res_item_t want);
		plan_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.item.op = op;
		r.item.channel = ch;
		r.item.level = lvl;
		r.item.fast_mode = fast;
		r.item.scl_sensed = scl;
		r.item.sda_sensed = sda;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic plan_row_t row_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
		plan_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic plan_row_t row_drain();
		plan_row_t r;
		r = '0;
		r.kind = ROW_DRAIN;
		return r;
	endfunction

	task automatic note_error(input string msg);
		$display("MISMATCH at result %0d: %s", results_seen, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [3:0] got,
		input logic [3:0] want);
		if (got !== want) note_error($sformatf("%s is %0h, should be %0h", name, got, want));
	endtask

	// Returns at the edge that takes the item; valid stays high for the caller's next item.
	task automatic put_item(input req_item_t it, input logic typed, input res_item_t want);
		int gap;
		res_item_t pred;
		gap = steady_feed ? 0 : (($urandom_range(0, 3) == 0) ? idle_len() : 0);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= it;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pred = bus_step(it);
		pin_results.push_back(typed ? want : pred);
		items_sent++;
		if (it.op == OP_WRITE) requests_sent++;
	endtask

	// Registers change only once every outstanding result is back.
	task automatic set_register(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
		req_valid <= 1'b0;
		while (pin_results.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_DEVICE_ADDRESS: dev_addr = val[6:0];
			CFG_WRITE_COMMAND: cmd_byte = val[7:0];
			CFG_HALF_PERIOD: half_ticks = val;
			CFG_STRETCH_LIMIT: stretch_lim = val;
			default: ;
		endcase
	endtask

	task automatic drain_bus();
		while (m_phase != PH_IDLE) put_item(pin_tick(88), 1'b0, '0);
	endtask

	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (res_item.done_res) writes_done++;
			if (res_item.done_res && res_item.ack_ok) writes_acked++;
			if (res_item.rejected) refusals++;
			if (pin_results.size() == 0) begin
				note_error("result arrived with none outstanding");
			end else begin
				want = pin_results.pop_front();
				check_field("scl_level", res_item.scl_level, want.scl_level);
				check_field("sda_levels", res_item.sda_levels, want.sda_levels);
				check_field("busy_res", res_item.busy_res, want.busy_res);
				check_field("done_res", res_item.done_res, want.done_res);
				check_field("ack_ok", res_item.ack_ok, want.ack_ok);
				check_field("rejected", res_item.rejected, want.rejected);
			end
		end
	end

	// Result side back-pressure: short stalls mostly, a few long ones, and quiet stretches.
	initial begin
		int quiet;
		@(posedge arst_n);
		forever begin
			quiet = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 12);
			repeat (quiet) @(posedge clk);
			res_stall <= 1'b1;
			repeat (idle_len()) @(posedge clk);
			res_stall <= 1'b0;
		end
	end

	initial begin
		#6000000;
		$display("Timed out with %0d results outstanding", pin_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		plan_row_t plan[$];
		plan_row_t row;
		res_item_t idle_pins;
		res_item_t taken;
		res_item_t refused;
		req_item_t stim;
		int n;
		int scl_pct;
		logic [15:0] half_v;
		logic [15:0] lim_v;
		logic [15:0] addr_v;
		logic [15:0] cmd_v;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req_item = '0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		items_sent = 0;
		requests_sent = 0;
		results_seen = 0;
		writes_done = 0;
		writes_acked = 0;
		refusals = 0;
		steady_feed = 1'b0;
		clear_model();

		idle_pins = bus_pins(1'b1, '1, 1'b0, 1'b0, 1'b0, 1'b0);
		taken = bus_pins(1'b1, '1, 1'b1, 1'b0, 1'b0, 1'b0);
		refused = bus_pins(1'b1, '1, 1'b0, 1'b0, 1'b0, 1'b1);

		// Idle ticks leave the lines released, whatever the unused fields carry.
		plan.push_back(row_item(OP_TICK, 3'd0, 16'h0000, 1'b0, 1'b0, 4'h0, 1'b1, idle_pins));
		plan.push_back(row_item(OP_TICK, 3'd7, 16'hFFFF, 1'b1, 1'b1, 4'hF, 1'b1, idle_pins));
		plan.push_back(row_item(OP_WRITE, 3'd4, 16'd100, 1'b0, 1'b0, 4'h0, 1'b1, refused));
		plan.push_back(row_item(OP_WRITE, 3'd7, 16'hFFFF, 1'b1, 1'b1, 4'hF, 1'b1, refused));
		// Saturated value with the registers as reset leaves them.
		plan.push_back(row_item(OP_WRITE, 3'd0, 16'hFFFF, 1'b0, 1'b0, 4'hF, 1'b1, taken));
		refused.busy_res = 1'b1;
		plan.push_back(row_item(OP_WRITE, 3'd1, 16'd0, 1'b1, 1'b1, 4'h0, 1'b1, refused));
		plan.push_back(row_item(OP_WRITE, 3'd6, 16'd0, 1'b0, 1'b0, 4'h0, 1'b1, refused));
		plan.push_back(row_item(OP_TICK, 3'd0, 16'd0, 1'b0, 1'b0, 4'h0, 1'b0, '0));
		// The timing is shortened while that write is under way.
		plan.push_back(row_reg(CFG_HALF_PERIOD, 16'd0));
		plan.push_back(row_reg(CFG_STRETCH_LIMIT, 16'd0));
		plan.push_back(row_drain());
		plan.push_back(row_reg(CFG_DEVICE_ADDRESS, 16'd127));
		plan.push_back(row_reg(CFG_WRITE_COMMAND, 16'd255));
		plan.push_back(row_item(OP_WRITE, 3'd3, 16'd4096, 1'b1, 1'b0, 4'h0, 1'b1, taken));
		plan.push_back(row_drain());
		plan.push_back(row_item(OP_WRITE, 3'd2, 16'd4095, 1'b0, 1'b1, 4'hF, 1'b1, taken));
		plan.push_back(row_drain());
		plan.push_back(row_reg(CFG_DEVICE_ADDRESS, 16'd0));
		plan.push_back(row_reg(CFG_HALF_PERIOD, 16'd3));
		plan.push_back(row_item(OP_WRITE, 3'd1, 16'h00A5, 1'b0, 1'b0, 4'h0, 1'b0, '0));
		plan.push_back(row_item(OP_TICK, 3'd0, 16'd0, 1'b0, 1'b1, 4'h0, 1'b0, '0));
		// The command and timing change while the write is under way.
		plan.push_back(row_reg(CFG_WRITE_COMMAND, 16'h00A5));
		plan.push_back(row_reg(CFG_HALF_PERIOD, 16'd0));
		plan.push_back(row_drain());
		plan.push_back(row_reg(CFG_STRETCH_LIMIT, 16'd2));
		plan.push_back(row_item(OP_WRITE, 3'd0, 16'd0, 1'b1, 1'b0, 4'h0, 1'b1, taken));
		plan.push_back(row_drain());

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			case (row.kind)
				ROW_ITEM: put_item(row.item, row.typed, row.want);
				ROW_REG: set_register(row.idx, row.val);
				default: drain_bus();
			endcase
		end

		for (int p = 0; p < 5; p++) begin
			addr_v = 16'($urandom_range(0, 127));
			cmd_v = 16'($urandom_range(0, 255));
			steady_feed = 1'b0;
			case (p)
				0: begin
					half_v = 16'd0;
					lim_v = 16'd0;
					n = 70;
					scl_pct = 90;
				end
				1: begin
					half_v = 16'd1;
					lim_v = 16'd3;
					addr_v = 16'd127;
					cmd_v = 16'd0;
					n = 70;
					scl_pct = 60;
				end
				2: begin
					// The engine barely moves here; the next phase resumes it mid-write.
					half_v = 16'hFFFF;
					lim_v = 16'hFFFF;
					addr_v = 16'd0;
					cmd_v = 16'd255;
					n = 20;
					scl_pct = 30;
				end
				3: begin
					half_v = 16'd0;
					lim_v = 16'd1;
					n = 70;
					scl_pct = 75;
					steady_feed = 1'b1;
				end
				default: begin
					half_v = 16'd2;
					lim_v = 16'd0;
					n = 50;
					scl_pct = 50;
				end
			endcase
			set_register(CFG_DEVICE_ADDRESS, addr_v);
			set_register(CFG_WRITE_COMMAND, cmd_v);
			set_register(CFG_HALF_PERIOD, half_v);
			set_register(CFG_STRETCH_LIMIT, lim_v);
			repeat (n) begin
				if (m_phase == PH_IDLE) stim = ($urandom_range(0, 3) == 0) ? dac_request()
					: pin_tick(scl_pct);
				else stim = ($urandom_range(0, 39) == 0) ? dac_request() : pin_tick(scl_pct);
				put_item(stim, 1'b0, '0);
			end
		end
		steady_feed = 1'b0;
		set_register(CFG_HALF_PERIOD, 16'd0);
		set_register(CFG_STRETCH_LIMIT, 16'd0);
		drain_bus();

		req_valid <= 1'b0;
		while (pin_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d items, %0d of them DAC requests; %0d were refused.",
			items_sent, requests_sent, refusals);
		$display("Bus writes finished: %0d, of which %0d were acknowledged throughout.",
			writes_done, writes_acked);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
